/* rtl/mwws_pkg.sv */
// Package: scan state types, character class and case folding helpers.
`timescale 1ns / 1ps

package mwws_pkg;

  localparam int unsigned MAX_WORD_CHARS = 8;
  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned POS_W          = 3;
  localparam int unsigned LEN_W          = 4;
  localparam int unsigned WORD_W         = MAX_WORD_CHARS * CHAR_W;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = WORD_W;

  localparam logic [CFG_IDX_W-1:0] CFG_WORD_CHARS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_LENGTH = 1'b1;

  localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;

  localparam logic [LEN_W-1:0] LEN_MIN = 4'd1;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_WORD_CHARS);

  typedef enum logic [3:0] {
    MODE_START  = 4'b0001,
    MODE_TAG    = 4'b0010,
    MODE_STRING = 4'b0100,
    MODE_WORD   = 4'b1000
  } scan_mode_t;

  typedef struct packed {
    scan_mode_t        mode;
    logic [POS_W-1:0]  match_position;
    logic [CHAR_W-1:0] closing_quote;
    logic              match_pending;
    logic              found_flag;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    mode:           MODE_START,
    match_position: '0,
    closing_quote:  '0,
    match_pending:  1'b0,
    found_flag:     1'b0
  };

  function automatic logic [CHAR_W-1:0] fold_ascii(input logic [CHAR_W-1:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  // Latin-1 letters and numbers
  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    logic r;
    r = 1'b0;
    if (c >= 8'h30 && c <= 8'h39) r = 1'b1;
    if (c >= 8'h41 && c <= 8'h5A) r = 1'b1;
    if (c >= 8'h61 && c <= 8'h7A) r = 1'b1;
    if (c == 8'hAA || c == 8'hB5 || c == 8'hBA) r = 1'b1;
    if (c == 8'hB2 || c == 8'hB3 || c == 8'hB9) r = 1'b1;
    if (c >= 8'hBC && c <= 8'hBE) r = 1'b1;
    if (c >= 8'hC0 && c != 8'hD7 && c != 8'hF7) r = 1'b1;
    return r;
  endfunction

endpackage

/* rtl/mwws_scan.sv */
// Next-state logic of the scanner for one text byte.
`timescale 1ns / 1ps

module mwws_scan (
  input  mwws_pkg::scan_state_t              cur,
  input  logic [mwws_pkg::CHAR_W-1:0]        text_byte,
  input  logic                               last_byte,
  input  logic [mwws_pkg::WORD_W-1:0]        word_chars,
  input  logic [mwws_pkg::LEN_W-1:0]         word_length,
  output mwws_pkg::scan_state_t              nxt,
  output logic                               found_here,
  output logic                               found_any
);

  logic [mwws_pkg::CHAR_W-1:0] c;
  logic [mwws_pkg::CHAR_W-1:0] want;
  logic [mwws_pkg::LEN_W-1:0]  len;
  logic [mwws_pkg::LEN_W-1:0]  pos_inc;
  logic                        c_alnum;
  logic                        here;
  mwws_pkg::scan_state_t       upd;

  assign c       = mwws_pkg::fold_ascii(text_byte);
  assign c_alnum = mwws_pkg::is_alnum(text_byte);
  assign want    = mwws_pkg::fold_ascii(word_chars[cur.match_position*mwws_pkg::CHAR_W +:
                                                   mwws_pkg::CHAR_W]);
  assign pos_inc = {1'b0, cur.match_position} + 4'd1;

  always_comb begin
    if (word_length < mwws_pkg::LEN_MIN) begin
      len = mwws_pkg::LEN_MIN;
    end else if (word_length > mwws_pkg::LEN_MAX) begin
      len = mwws_pkg::LEN_MAX;
    end else begin
      len = word_length;
    end
  end

  always_comb begin
    upd               = cur;
    upd.match_pending = 1'b0;
    here              = cur.match_pending && !c_alnum;

    if (cur.mode == mwws_pkg::MODE_STRING) begin
      if (c == cur.closing_quote) upd.mode = mwws_pkg::MODE_START;
    end else if (c == mwws_pkg::CH_SQUOTE || c == mwws_pkg::CH_DQUOTE) begin
      upd.closing_quote = c;
      upd.mode          = mwws_pkg::MODE_STRING;
    end else if (c == mwws_pkg::CH_LT) begin
      upd.mode = mwws_pkg::MODE_TAG;
    end else if (cur.mode == mwws_pkg::MODE_TAG) begin
      if (c == mwws_pkg::CH_GT) upd.mode = mwws_pkg::MODE_START;
    end else if (cur.mode == mwws_pkg::MODE_WORD) begin
      if (!c_alnum) upd.mode = mwws_pkg::MODE_START;
    end else begin
      if ({1'b0, cur.match_position} < len && want == c) begin
        if (pos_inc >= len) begin
          upd.match_position = '0;
          if (last_byte) begin
            here = 1'b1;
          end else begin
            upd.match_pending = 1'b1;
          end
        end else begin
          upd.match_position = pos_inc[mwws_pkg::POS_W-1:0];
        end
      end else begin
        upd.match_position = '0;
        upd.mode = c_alnum ? mwws_pkg::MODE_WORD : mwws_pkg::MODE_START;
      end
    end

    upd.found_flag = cur.found_flag | here;
    nxt            = last_byte ? mwws_pkg::SCAN_RESET : upd;
  end

  assign found_here = here;
  assign found_any  = upd.found_flag;

endmodule

/* rtl/markup_whole_word_search.sv */
// Top level: whole-word search over a markup byte stream.
//
// Input channel: one text byte per item (in_text_byte, in_last_byte), taken
// when in_valid is high and in_stall is low. Result channel: one result per
// input item (out_found_here, out_found_any, out_search_done) under
// out_valid / out_stall.
// Each accepted byte's result shows on out_* in the next cycle.
// Throughput: one item per cycle while not stalled; the scanner state update
// is a single compare-and-select step between port and result register.
// The input stalls only while a result waits in the result register and the
// receiver holds out_stall high; results are never lost or repeated.
// Configuration: cfg_we writes word_chars (index 0) or word_length (index 1);
// write only while no item is in flight.
// Reset (synchronous, rst_n low): scanner state back to word start, no
// result held, word_chars = 0, word_length = 1. After each item marked
// in_last_byte the scanner state returns to its reset value as well.
`timescale 1ns / 1ps

module markup_whole_word_search (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mwws_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mwws_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mwws_pkg::CHAR_W-1:0]         in_text_byte,
  input  logic                                in_last_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_found_here,
  output logic                                out_found_any,
  output logic                                out_search_done
);

  logic [mwws_pkg::WORD_W-1:0] word_chars_r;
  logic [mwws_pkg::LEN_W-1:0]  word_length_r;
  mwws_pkg::scan_state_t       state_r;
  mwws_pkg::scan_state_t       state_nxt;
  logic                        here_nxt;
  logic                        any_nxt;
  logic                        out_valid_r;
  logic                        found_here_r;
  logic                        found_any_r;
  logic                        search_done_r;
  logic                        in_acc;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  mwws_scan u_scan (
    .cur         (state_r),
    .text_byte   (in_text_byte),
    .last_byte   (in_last_byte),
    .word_chars  (word_chars_r),
    .word_length (word_length_r),
    .nxt         (state_nxt),
    .found_here  (here_nxt),
    .found_any   (any_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_chars_r  <= '0;
      word_length_r <= mwws_pkg::LEN_MIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mwws_pkg::CFG_WORD_CHARS:  word_chars_r  <= cfg_data;
        mwws_pkg::CFG_WORD_LENGTH: word_length_r <= cfg_data[mwws_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mwws_pkg::SCAN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) state_r <= state_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      found_here_r  <= here_nxt;
      found_any_r   <= any_nxt;
      search_done_r <= in_last_byte;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found_here  = found_here_r;
  assign out_found_any   = found_any_r;
  assign out_search_done = search_done_r;

endmodule

/* rtl/mwws_checker.sv */
// Port-level checker for the whole-word search block, with its bind.
`timescale 1ns / 1ps

module mwws_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic in_last_byte,
  input logic out_valid,
  input logic out_stall,
  input logic out_found_here,
  input logic out_found_any,
  input logic out_search_done
);

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found_here) &&
      $stable(out_found_any) && $stable(out_search_done))
    else $error("stalled result item changed");

  a_here_sets_any: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found_here |-> out_found_any)
    else $error("found_here without found_any");

  a_no_needless_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled while result side free");

  a_last_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid && (out_search_done == $past(in_last_byte)))
    else $error("accepted item did not give its result");

endmodule

bind markup_whole_word_search mwws_checker u_mwws_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_last_byte    (in_last_byte),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_found_here  (out_found_here),
  .out_found_any   (out_found_any),
  .out_search_done (out_search_done)
);

/* dv/tb_markup_whole_word_search.sv */
// Self-checking testbench for the whole-word markup search: byte streams in, per-byte hits out.
`timescale 1ns / 1ps

module tb_markup_whole_word_search;

  localparam int unsigned BYTES_PER_SETTING = 200;
  localparam int unsigned N_SETTINGS        = 10;
  localparam int unsigned LONG_HOLD         = 60;
  localparam logic [7:0] SEPS [0:9] = '{8'h20, 8'h2C, 8'h2E, 8'h0A, 8'h00,
                                        8'hD7, 8'hF7, 8'h2D, 8'h7F, 8'hA0};

  class whole_word_tracker;
    typedef struct packed {
      logic here;
      logic any;
      logic done;
    } hit_t;

    hit_t                        expected_hits[$];
    logic [mwws_pkg::WORD_W-1:0] word;
    logic [mwws_pkg::LEN_W-1:0]  wlen;
    mwws_pkg::scan_mode_t        mode;
    logic [mwws_pkg::LEN_W-1:0]  pos;
    logic [7:0]                  quote_ch;
    logic                        pending_hit;
    logic                        found;
    int                          errors, n_bytes, n_hits, n_texts;

    function new();
      word = '0;
      wlen = mwws_pkg::LEN_MIN;
      restart();
    endfunction

    function void restart();
      mode        = mwws_pkg::MODE_START;
      pos         = '0;
      quote_ch    = '0;
      pending_hit = 1'b0;
      found       = 1'b0;
    endfunction

    static function logic [7:0] lower(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? (c ^ 8'h20) : c;
    endfunction

    // Latin-1 letters and numbers
    static function bit is_word_char(logic [7:0] c);
      logic [7:0] l;
      l = c | 8'h20;
      if (c >= "0" && c <= "9") return 1'b1;
      if (l >= "a" && l <= "z") return 1'b1;
      if (c >= 8'hC0) return (c != 8'hD7) && (c != 8'hF7);
      return c == 8'hAA || c == 8'hB5 || c == 8'hBA || c == 8'hB2 || c == 8'hB3 ||
             c == 8'hB9 || (c >= 8'hBC && c <= 8'hBE);
    endfunction

    function void set_reg(logic [mwws_pkg::CFG_IDX_W-1:0] idx,
                          logic [mwws_pkg::CFG_DATA_W-1:0] d);
      if (idx == mwws_pkg::CFG_WORD_CHARS) word = d;
      else wlen = d[mwws_pkg::LEN_W-1:0];
    endfunction

    function int pending();
      return expected_hits.size();
    endfunction

    function void take_byte(logic [7:0] raw, logic last);
      logic [7:0]                 c, want;
      logic [mwws_pkg::LEN_W-1:0] len;
      logic                       here;
      hit_t                       h;
      c    = lower(raw);
      len  = (wlen < mwws_pkg::LEN_MIN) ? mwws_pkg::LEN_MIN :
             ((wlen > mwws_pkg::LEN_MAX) ? mwws_pkg::LEN_MAX : wlen);
      here = 1'b0;
      if (pending_hit) begin
        here        = !is_word_char(raw);
        pending_hit = 1'b0;
      end
      if (mode == mwws_pkg::MODE_STRING) begin
        if (c == quote_ch) mode = mwws_pkg::MODE_START;
      end else if (c == mwws_pkg::CH_SQUOTE || c == mwws_pkg::CH_DQUOTE) begin
        quote_ch = c;
        mode     = mwws_pkg::MODE_STRING;
      end else if (c == mwws_pkg::CH_LT) begin
        mode = mwws_pkg::MODE_TAG;
      end else if (mode == mwws_pkg::MODE_TAG) begin
        if (c == mwws_pkg::CH_GT) mode = mwws_pkg::MODE_START;
      end else if (mode == mwws_pkg::MODE_WORD) begin
        if (!is_word_char(c)) mode = mwws_pkg::MODE_START;
      end else begin
        want = lower(word[8*pos[2:0] +: 8]);
        if (pos < len && want == c) begin
          pos = pos + 1'b1;
          if (pos >= len) begin
            pos = '0;
            if (last) here = 1'b1;
            else pending_hit = 1'b1;
          end
        end else begin
          pos  = '0;
          mode = is_word_char(c) ? mwws_pkg::MODE_WORD : mwws_pkg::MODE_START;
        end
      end
      found  = found | here;
      h.here = here;
      h.any  = found;
      h.done = last;
      expected_hits.push_back(h);
      n_bytes++;
      if (here) n_hits++;
      if (last) begin
        n_texts++;
        restart();
      end
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task check_hit(logic here, logic any, logic done);
      hit_t h;
      if (expected_hits.size() == 0) begin
        report($sformatf("result with no byte outstanding (here=%b any=%b done=%b)",
                         here, any, done));
      end else begin
        h = expected_hits.pop_front();
        if (here !== h.here) report($sformatf("found_here %b, want %b", here, h.here));
        if (any !== h.any) report($sformatf("found_any %b, want %b", any, h.any));
        if (done !== h.done) report($sformatf("search_done %b, want %b", done, h.done));
      end
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [mwws_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mwws_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic [mwws_pkg::CHAR_W-1:0]     in_text_byte;
  logic                            in_last_byte;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            out_found_here;
  logic                            out_found_any;
  logic                            out_search_done;

  whole_word_tracker               trk;
  logic [mwws_pkg::WORD_W-1:0]     cur_word;
  int unsigned                     cur_len;
  logic [7:0]                      text_bytes[$];
  bit                              calm;
  bit                              long_hold_req;

  markup_whole_word_search dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #(2_000_000);
    $display("tb_markup_whole_word_search NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      trk.check_hit(out_found_here, out_found_any, out_search_done);
  end

  // receiver: short random stalls, one long hold on request
  always begin
    @(negedge clk);
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      out_stall <= 1'b1;
      repeat (LONG_HOLD) @(negedge clk);
      out_stall <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 4)) @(negedge clk);
      out_stall <= 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    trk.take_byte(b, last);
    @(negedge clk);
  endtask

  task automatic send_str(input string s, input bit ends_text);
    int k;
    for (k = 0; k < s.len(); k++) send_byte(s[k], ends_text && k == s.len() - 1);
  endtask

  task automatic send_text();
    int k;
    for (k = 0; k < text_bytes.size(); k++) send_byte(text_bytes[k], k == text_bytes.size() - 1);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (trk.pending() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic load_word(input logic [mwws_pkg::WORD_W-1:0] chars,
                           input logic [mwws_pkg::LEN_W-1:0] len);
    logic [mwws_pkg::CFG_DATA_W-1:0] len_data;
    len_data                      = {$urandom, $urandom};
    len_data[mwws_pkg::LEN_W-1:0] = len;
    cfg_we    <= 1'b1;
    cfg_index <= mwws_pkg::CFG_WORD_CHARS;
    cfg_data  <= chars;
    trk.set_reg(mwws_pkg::CFG_WORD_CHARS, chars);
    @(negedge clk);
    cfg_index <= mwws_pkg::CFG_WORD_LENGTH;
    cfg_data  <= len_data;
    trk.set_reg(mwws_pkg::CFG_WORD_LENGTH, len_data);
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_word = chars;
    cur_len  = (len == 0) ? 1 : ((len > mwws_pkg::LEN_MAX) ? mwws_pkg::LEN_MAX : len);
  endtask

  function automatic logic [7:0] random_alnum();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (!whole_word_tracker::is_word_char(b));
    return b;
  endfunction

  function automatic logic [mwws_pkg::WORD_W-1:0] random_word();
    logic [mwws_pkg::WORD_W-1:0] w;
    logic [7:0]                  ch;
    int                          k, r;
    for (k = 0; k < mwws_pkg::MAX_WORD_CHARS; k++) begin
      r = $urandom_range(0, 9);
      if (r < 5) begin
        ch = 8'h61 + 8'($urandom_range(0, 25));
        if ($urandom_range(0, 1)) ch = ch ^ 8'h20;
      end else if (r < 7) begin
        ch = 8'h30 + 8'($urandom_range(0, 9));
      end else if (r < 8) begin
        ch = random_alnum();
      end else begin
        ch = 8'($urandom_range(0, 255));
      end
      w[8*k +: 8] = ch;
    end
    return w;
  endfunction

  // copy of the first n chars of the searched word, ASCII letters in random case
  function automatic void push_word(int n);
    logic [7:0] ch;
    int         k;
    for (k = 0; k < n; k++) begin
      ch = cur_word[8*k +: 8];
      if ((ch | 8'h20) >= "a" && (ch | 8'h20) <= "z" && $urandom_range(0, 1)) ch = ch ^ 8'h20;
      text_bytes.push_back(ch);
    end
  endfunction

  function automatic void push_noise(int n);
    repeat (n) text_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void build_text();
    int         k;
    logic [7:0] q;
    text_bytes.delete();
    repeat ($urandom_range(1, 8)) begin
      k = $urandom_range(0, 99);
      if (k < 35) begin
        push_word(cur_len);
      end else if (k < 45) begin
        push_word($urandom_range(1, cur_len));
      end else if (k < 60) begin
        text_bytes.push_back(SEPS[$urandom_range(0, 9)]);
      end else if (k < 70) begin
        repeat ($urandom_range(1, 3)) text_bytes.push_back(random_alnum());
      end else if (k < 78) begin
        text_bytes.push_back(mwws_pkg::CH_LT);
        push_noise($urandom_range(0, 3));
        if ($urandom_range(0, 1)) push_word(cur_len);
        text_bytes.push_back(mwws_pkg::CH_GT);
      end else if (k < 90) begin
        q = $urandom_range(0, 1) ? mwws_pkg::CH_SQUOTE : mwws_pkg::CH_DQUOTE;
        text_bytes.push_back(q);
        if ($urandom_range(0, 1)) push_word(cur_len);
        if ($urandom_range(0, 2) == 0)
          text_bytes.push_back(q ^ (mwws_pkg::CH_SQUOTE ^ mwws_pkg::CH_DQUOTE));
        if ($urandom_range(0, 2) == 0) text_bytes.push_back(mwws_pkg::CH_LT);
        push_noise($urandom_range(0, 2));
        if ($urandom_range(0, 9) != 0) text_bytes.push_back(q);
      end else begin
        push_noise($urandom_range(1, 3));
      end
    end
  endfunction

  initial begin
    int unsigned sent, w, ph;
    trk           = new();
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = mwws_pkg::CFG_WORD_CHARS;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_text_byte  = '0;
    in_last_byte  = 1'b0;
    calm          = 1'b0;
    long_hold_req = 1'b0;
    cur_word      = '0;
    cur_len       = 1;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: word "Ab"; boundary, tag, string and case handling
    load_word(64'h0000_0000_0000_6241, 4'd2);
    send_byte(8'h00, 1'b0);
    send_str("AB", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_str("<ab> 'ab<'ab", 1'b1);
    send_str("ab", 1'b0);
    send_byte(8'hD7, 1'b1);
    send_str("\"'ab\"ab", 1'b0);
    send_byte(8'hB5, 1'b1);

    for (ph = 0; ph < N_SETTINGS; ph++) begin
      settle();
      case (ph)
        0:       load_word('0, 4'd0);
        1:       load_word('1, 4'd15);
        2:       load_word(random_word(), 4'd8);
        3:       load_word(random_word(), 4'd1);
        default: load_word(random_word(), 4'($urandom_range(0, 15)));
      endcase
      if (ph == N_SETTINGS - 1) calm = 1'b1;
      if (ph == 4) long_hold_req = 1'b1;
      sent = 0;
      while (sent < BYTES_PER_SETTING) begin
        build_text();
        send_text();
        sent += text_bytes.size();
      end
    end

    in_valid <= 1'b0;
    for (w = 0; w < 1000 && trk.pending() != 0; w++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (trk.pending() != 0) trk.report($sformatf("%0d results never arrived", trk.pending()));
    $display("Covered %0d texts, %0d bytes under %0d word settings;", trk.n_texts,
             trk.n_bytes, N_SETTINGS + 1);
    $display("%0d whole-word hits expected, %0d mismatches.", trk.n_hits, trk.errors);
    if (trk.errors == 0) begin
      $display("tb_markup_whole_word_search OK");
    end else begin
      $display("tb_markup_whole_word_search NOT OK");
    end
    $finish;
  end

endmodule
